// ===== hdl/mss_pkg.sv =====
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types and codes for the multi-stack shared store: operation kinds,
// result status codes, controller state encoding and payload widths.
// ----------------------------------------------------------------------------
package mss_pkg;

    // payload widths fixed by the transaction format
    localparam int DATA_W   = 32;
    localparam int SID_IN_W = 2;
    localparam int STATUS_W = 2;

    // operation kinds
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

    // controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PUSH = 4'b0010,
        ST_POP1 = 4'b0100,
        ST_POP2 = 4'b1000
    } state_t;

endpackage

// ===== hdl/mss_if.sv =====
// ----------------------------------------------------------------------------
// mss_if
// Valid/ready channels of the multi-stack shared store: the command channel
// (push or pop) and the response channel (popped word and status).
// ----------------------------------------------------------------------------
interface mss_cmd_if;

    logic                                  valid;
    logic                                  ready;
    logic                                  kind;
    logic [mss_pkg::SID_IN_W-1:0]          stack_id;
    logic signed [mss_pkg::DATA_W-1:0]     value;

    modport source (output valid, output kind, output stack_id, output value, input ready);
    modport sink   (input valid, input kind, input stack_id, input value, output ready);

endinterface

interface mss_rsp_if;

    logic                                  valid;
    logic                                  ready;
    logic signed [mss_pkg::DATA_W-1:0]     popped_value;
    logic [mss_pkg::STATUS_W-1:0]          status;

    modport source (output valid, output popped_value, output status, input ready);
    modport sink   (input valid, input popped_value, input status, output ready);

endinterface

// ===== hdl/mss_ram.sv =====
// ----------------------------------------------------------------------------
// mss_ram
// Generic single-clock RAM with one write port and one read port. Read data
// is registered and holds while no read is enabled.
// ----------------------------------------------------------------------------
module mss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/multi_stack_shared_store_core.sv =====
// ----------------------------------------------------------------------------
// multi_stack_shared_store_core
// NUM_STACKS LIFO stacks sharing one data store of CAPACITY words, linked
// through a per-slot link store with unused slots kept on a free list.
// ----------------------------------------------------------------------------
// Every command transaction gives exactly one response transaction. A push
// passes through state PUSH and a pop through POP1 and POP2 before the next
// acceptance: the stack top comes out of the top-of-stack memory in the
// cycle after acceptance, and a pop then needs a second memory read of the
// link and data words at that top before it can write back. A failed push
// (overflow, stack number out of range) takes the same path as a push; a
// failed pop (underflow, stack number out of range) ends in POP1 once the
// top is known. Failed operations change nothing. The block is usable
// straight out of reset: the top-of-stack memory has a valid bit per stack
// and the link memory is tracked by a fill count, so there is no clearing
// pass. No command is accepted while a response is waiting and not taken in
// that cycle.
module multi_stack_shared_store_core #(
    parameter int NUM_STACKS = 4,
    parameter int CAPACITY   = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    mss_cmd_if.sink     cmd,
    mss_rsp_if.source   rsp
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PTR_W  = ADDR_W + 1;
    localparam int SID_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam logic [PTR_W-1:0] EMPTY = PTR_W'(CAPACITY);

    // control registers
    mss_pkg::state_t               state_reg, state_next;
    logic [PTR_W-1:0]              free_head_reg, free_head_next;
    logic [PTR_W-1:0]              hwm_reg, hwm_next;
    logic [NUM_STACKS-1:0]         top_vld_reg, top_vld_next;
    logic                          out_valid_reg, out_valid_next;

    // payload registers
    logic [SID_W-1:0]              sid_reg;
    logic                          in_range_reg;
    logic [mss_pkg::DATA_W-1:0]    value_reg;
    logic [PTR_W-1:0]              top_reg, top_next;
    logic [ADDR_W-1:0]             link_qaddr_reg;
    logic [mss_pkg::DATA_W-1:0]    popped_reg, popped_next;
    logic [mss_pkg::STATUS_W-1:0]  status_reg, status_next;

    // memory ports
    logic                          tops_we;
    logic [PTR_W-1:0]              tops_wdata;
    logic [PTR_W-1:0]              tops_q;
    logic                          link_we, link_re;
    logic [ADDR_W-1:0]             link_waddr, link_raddr;
    logic [PTR_W-1:0]              link_wdata, link_q;
    logic                          data_we, data_re;
    logic [ADDR_W-1:0]             data_raddr;
    logic [mss_pkg::DATA_W-1:0]    data_q;

    logic                          cmd_fire;
    logic [PTR_W-1:0]              top_val;
    logic [PTR_W-1:0]              link_val;
    logic [PTR_W-1:0]              link_qaddr_ext;

    // handshakes
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == mss_pkg::ST_IDLE) && (!out_valid_reg || rsp.ready);

    assign rsp.valid        = out_valid_reg;
    assign rsp.popped_value = popped_reg;
    assign rsp.status       = status_reg;

    // stack top as read, empty for an unwritten or out-of-range stack
    assign top_val = (in_range_reg && top_vld_reg[sid_reg]) ? tops_q : EMPTY;

    // link word as read: slots at or above the fill count still hold their reset link
    assign link_qaddr_ext = {1'b0, link_qaddr_reg};
    assign link_val = (link_qaddr_ext >= hwm_reg) ? (link_qaddr_ext + PTR_W'(1)) : link_q;

    // top-of-stack memory, read at acceptance
    mss_ram #(
        .WIDTH (PTR_W),
        .DEPTH (NUM_STACKS)
    ) u_tops_ram (
        .clk   (clk),
        .we    (tops_we),
        .waddr (sid_reg),
        .wdata (tops_wdata),
        .re    (cmd_fire),
        .raddr (SID_W'(cmd.stack_id)),
        .rdata (tops_q)
    );

    // link memory
    mss_ram #(
        .WIDTH (PTR_W),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_q)
    );

    // data memory
    mss_ram #(
        .WIDTH (mss_pkg::DATA_W),
        .DEPTH (CAPACITY)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (free_head_reg[ADDR_W-1:0]),
        .wdata (value_reg),
        .re    (data_re),
        .raddr (data_raddr),
        .rdata (data_q)
    );

    // sequencer: read, modify, write back
    always_comb
    begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        hwm_next       = hwm_reg;
        top_vld_next   = top_vld_reg;
        top_next       = top_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        popped_next    = popped_reg;
        status_next    = status_reg;
        tops_we        = 1'b0;
        tops_wdata     = top_val;
        link_we        = 1'b0;
        link_waddr     = free_head_reg[ADDR_W-1:0];
        link_wdata     = top_val;
        link_re        = 1'b0;
        link_raddr     = free_head_reg[ADDR_W-1:0];
        data_we        = 1'b0;
        data_re        = 1'b0;
        data_raddr     = top_val[ADDR_W-1:0];

        unique case (state_reg)
            mss_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (cmd.kind == mss_pkg::KIND_PUSH)
                    begin
                        link_re    = 1'b1;
                        state_next = mss_pkg::ST_PUSH;
                    end
                    else
                    begin
                        state_next = mss_pkg::ST_POP1;
                    end
                end
            end
            mss_pkg::ST_PUSH:
            begin
                out_valid_next = 1'b1;
                popped_next    = '0;
                if (in_range_reg && (free_head_reg < EMPTY))
                begin
                    // free head becomes the new top, linked above the old top
                    free_head_next        = link_val;
                    link_we               = 1'b1;
                    link_wdata            = top_val;
                    data_we               = 1'b1;
                    tops_we               = 1'b1;
                    tops_wdata            = free_head_reg;
                    top_vld_next[sid_reg] = 1'b1;
                    if (free_head_reg == hwm_reg)
                    begin
                        hwm_next = hwm_reg + PTR_W'(1);
                    end
                    status_next = mss_pkg::STATUS_OK;
                end
                else
                begin
                    status_next = mss_pkg::STATUS_OVERFLOW;
                end
                state_next = mss_pkg::ST_IDLE;
            end
            mss_pkg::ST_POP1:
            begin
                top_next = top_val;
                if (top_val < EMPTY)
                begin
                    link_re    = 1'b1;
                    link_raddr = top_val[ADDR_W-1:0];
                    data_re    = 1'b1;
                    state_next = mss_pkg::ST_POP2;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    popped_next    = '0;
                    status_next    = mss_pkg::STATUS_UNDERFLOW;
                    state_next     = mss_pkg::ST_IDLE;
                end
            end
            mss_pkg::ST_POP2:
            begin
                // unlink the top slot and return it to the free list
                tops_we        = 1'b1;
                tops_wdata     = link_val;
                link_we        = 1'b1;
                link_waddr     = top_reg[ADDR_W-1:0];
                link_wdata     = free_head_reg;
                free_head_next = top_reg;
                out_valid_next = 1'b1;
                popped_next    = data_q;
                status_next    = mss_pkg::STATUS_OK;
                state_next     = mss_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mss_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mss_pkg::ST_IDLE;
            free_head_reg <= '0;
            hwm_reg       <= '0;
            top_vld_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            hwm_reg       <= hwm_next;
            top_vld_reg   <= top_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // transaction payload
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            sid_reg      <= SID_W'(cmd.stack_id);
            in_range_reg <= 32'(cmd.stack_id) < NUM_STACKS;
            value_reg    <= cmd.value;
        end
        if (link_re)
        begin
            link_qaddr_reg <= link_raddr;
        end
        top_reg    <= top_next;
        popped_reg <= popped_next;
        status_reg <= status_next;
    end

`ifndef SYNTH
    // an accepted command always finds the response register free afterwards
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire |=> !out_valid_reg)
        else $error("command accepted while a response was pending");

    // the free list head never runs beyond the fill count
    assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg <= hwm_reg)
        else $error("free list head beyond the link fill count");

    // the fill count never goes back
    assert property (@(posedge clk) disable iff (!rst_n)
        hwm_reg >= $past(hwm_reg))
        else $error("link fill count decreased");

    // failed operations return a zero word
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != mss_pkg::STATUS_OK)) |-> (rsp.popped_value == '0))
        else $error("non-zero word on a failed operation");
`endif

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for multi_stack_shared_store_core. Push and pop
// transactions go in on the command channel and are predicted by a
// linked-slot model of the stacks and free list held in a scoreboard.
// Each response is checked in order against that prediction. Stimulus is
// a short directed run, then random mixed, fill-to-overflow and
// drain-to-underflow phases, with random gaps on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam int NSTK      = 4;
    localparam int CAP       = 256;
    localparam int SLOT_W    = $clog2(CAP + 1);
    localparam int SID_W     = mss_pkg::SID_IN_W;
    localparam int CYCLE_CAP = 400000;
    localparam int SETTLE    = 10;

    // expected response of one command transaction
    typedef struct {
        logic signed [mss_pkg::DATA_W-1:0]  popped;
        logic [mss_pkg::STATUS_W-1:0]       status;
    } stack_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: slot-linked stack model and queue of expected responses
    // ------------------------------------------------------------------------
    class stack_scoreboard;

        logic [mss_pkg::DATA_W-1:0]  words [CAP];
        logic [SLOT_W-1:0]           links [CAP];
        logic [SLOT_W-1:0]           tops  [NSTK];
        logic [SLOT_W-1:0]           free_head;
        int                          depth [NSTK];
        int                          used;
        int                          errors;
        stack_result_t               awaited_q [$];

        function new();
            for (int i = 0; i < CAP; i++)
            begin
                words[i] = '0;
                links[i] = SLOT_W'(i + 1);
            end
            for (int i = 0; i < NSTK; i++)
            begin
                tops[i]  = SLOT_W'(CAP);
                depth[i] = 0;
            end
            free_head = '0;
            used      = 0;
            errors    = 0;
        endfunction

        // apply one accepted command to the model and queue its response
        function void note_command(logic kind, logic [SID_W-1:0] sid,
                                   logic [mss_pkg::DATA_W-1:0] val);
            logic [SLOT_W-1:0] slot;
            stack_result_t     res;
            res.popped = '0;
            res.status = mss_pkg::STATUS_OK;
            if (kind == mss_pkg::KIND_PUSH)
            begin
                slot = free_head;
                if (sid >= NSTK || slot >= CAP)
                    res.status = mss_pkg::STATUS_OVERFLOW;
                else
                begin
                    free_head   = links[slot];
                    links[slot] = tops[sid];
                    tops[sid]   = slot;
                    words[slot] = val;
                    depth[sid]++;
                    used++;
                end
            end
            else
            begin
                slot = (sid < NSTK) ? tops[sid] : SLOT_W'(CAP);
                if (slot >= CAP)
                    res.status = mss_pkg::STATUS_UNDERFLOW;
                else
                begin
                    tops[sid]   = links[slot];
                    links[slot] = free_head;
                    free_head   = slot;
                    res.popped  = words[slot];
                    depth[sid]--;
                    used--;
                end
            end
            awaited_q.push_back(res);
        endfunction

        // compare one response transaction with the oldest expectation
        function void check_response(logic signed [mss_pkg::DATA_W-1:0] popped,
                                     logic [mss_pkg::STATUS_W-1:0] status);
            stack_result_t exp_res;
            if (awaited_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] unexpected response: popped=%h status=%0d",
                             $time, popped, status);
                return;
            end
            exp_res = awaited_q.pop_front();
            if (popped !== exp_res.popped || status !== exp_res.status)
            begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] mismatch: popped exp %h got %h, status exp %0d got %0d",
                             $time, exp_res.popped, popped, exp_res.status, status);
            end
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        // a stack holding something, searched from a random start
        function int nonempty_stack();
            int start;
            start = $urandom_range(0, NSTK - 1);
            for (int i = 0; i < NSTK; i++)
                if (depth[(start + i) % NSTK] > 0)
                    return (start + i) % NSTK;
            return start;
        endfunction

    endclass

    logic clk;
    logic rst_n;
    int   cycles;
    bit   send_quiet;
    bit   take_quiet;

    mss_cmd_if cmd ();
    mss_rsp_if rsp ();

    stack_scoreboard board = new();

    multi_stack_shared_store_core #(
        .NUM_STACKS (NSTK),
        .CAPACITY   (CAP)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_CAP)
            begin
                $display("timeout after %0d cycles, %0d responses outstanding",
                         cycles, board.pending());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // data word, with the extremes turning up now and then
    function automatic logic [mss_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // response side: random back-pressure with quiet stretches
    initial
    begin
        int stall;
        rsp.ready  <= 1'b0;
        take_quiet = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 49) == 0)
                take_quiet = ~take_quiet;
            stall = take_quiet ? 0 : pick_gap();
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // response monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1)
            board.check_response(rsp.popped_value, rsp.status);
    end

    // one command transaction, after an optional gap
    task automatic send_command(input logic k, input logic [SID_W-1:0] sid,
                                input logic [mss_pkg::DATA_W-1:0] val, input int gap);
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid    <= 1'b1;
        cmd.kind     <= k;
        cmd.stack_id <= sid;
        cmd.value    <= val;
        do
            @(posedge clk);
        while (cmd.ready !== 1'b1);
        board.note_command(k, sid, val);
    endtask

    // stop sending and wait for every outstanding response
    task automatic drain_responses();
        cmd.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // one random command; aimed pops mostly pick a stack with something in it
    task automatic random_command(input int push_pct, input bit aimed);
        logic             k;
        logic [SID_W-1:0] sid;
        k   = ($urandom_range(0, 99) < push_pct) ? mss_pkg::KIND_PUSH : mss_pkg::KIND_POP;
        sid = SID_W'($urandom_range(0, NSTK - 1));
        if (k == mss_pkg::KIND_POP && aimed && board.used != 0 && $urandom_range(0, 4) != 0)
            sid = SID_W'(board.nonempty_stack());
        if ($urandom_range(0, 39) == 0)
            send_quiet = ~send_quiet;
        send_command(k, sid, pick_word(), send_quiet ? 0 : pick_gap());
    endtask

    // stimulus
    initial
    begin
        int extra;
        rst_n        <= 1'b0;
        cmd.valid    <= 1'b0;
        cmd.kind     <= mss_pkg::KIND_PUSH;
        cmd.stack_id <= '0;
        cmd.value    <= '0;
        send_quiet   = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stacks underflow straight after reset
        for (int s = 0; s < NSTK; s++)
            send_command(mss_pkg::KIND_POP, SID_W'(s), 32'h0, 0);
        // extreme words into every stack
        send_command(mss_pkg::KIND_PUSH, 2'd0, 32'h7FFF_FFFF, 0);
        send_command(mss_pkg::KIND_PUSH, 2'd1, 32'h8000_0000, 1);
        send_command(mss_pkg::KIND_PUSH, 2'd2, 32'h0000_0000, 0);
        send_command(mss_pkg::KIND_PUSH, 2'd3, 32'hFFFF_FFFF, 2);
        send_command(mss_pkg::KIND_PUSH, 2'd0, 32'h5555_5555, 0);
        send_command(mss_pkg::KIND_PUSH, 2'd0, 32'hAAAA_AAAA, 0);
        // last in, first out, then underflow on the emptied stack
        send_command(mss_pkg::KIND_POP, 2'd0, 32'hFFFF_FFFF, 0);
        send_command(mss_pkg::KIND_POP, 2'd0, 32'h0, 0);
        send_command(mss_pkg::KIND_POP, 2'd0, 32'h0, 3);
        send_command(mss_pkg::KIND_POP, 2'd0, 32'h0, 0);
        send_command(mss_pkg::KIND_POP, 2'd1, 32'h0, 0);
        send_command(mss_pkg::KIND_POP, 2'd2, 32'h0, 0);
        send_command(mss_pkg::KIND_POP, 2'd3, 32'h0, 0);
        // freed slots reused across stacks
        send_command(mss_pkg::KIND_PUSH, 2'd3, 32'h0000_0001, 0);
        send_command(mss_pkg::KIND_PUSH, 2'd3, 32'h0000_0002, 0);
        send_command(mss_pkg::KIND_POP, 2'd3, 32'h0, 0);
        send_command(mss_pkg::KIND_PUSH, 2'd2, 32'h0000_0003, 0);
        send_command(mss_pkg::KIND_POP, 2'd3, 32'h0, 0);
        send_command(mss_pkg::KIND_POP, 2'd2, 32'h0, 0);

        // hold off until every response is back
        drain_responses();

        // mixed traffic
        for (int i = 0; i < 150; i++)
            random_command(50, 1'b1);
        drain_responses();

        // fill the store until pushes overflow
        extra = 0;
        while (extra < 25)
        begin
            random_command(90, 1'b0);
            if (board.used == CAP)
                extra++;
        end

        // drain it until pops underflow
        extra = 0;
        while (extra < 25)
        begin
            random_command(10, 1'b1);
            if (board.used == 0)
                extra++;
        end

        // closing mixed traffic
        for (int i = 0; i < 90; i++)
            random_command(55, 1'b1);

        drain_responses();
        repeat (SETTLE) @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0d mismatches, %0d responses outstanding",
                     board.errors, board.pending());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/mss_pkg.sv
hdl/mss_if.sv
hdl/mss_ram.sv
hdl/multi_stack_shared_store_core.sv
tb/testbench.sv
